### src/cosine_term_canonicalizer_assert.svh
// Assertion macros shared by the cosine term canonicalizer modules.
`ifndef COSINE_TERM_CANONICALIZER_ASSERT_SVH
`define COSINE_TERM_CANONICALIZER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CTC_ASSERT_IMPLY(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define CTC_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

### src/ctc_pkg.sv
// Shared types, constants and helper functions of the cosine term canonicalizer.
`default_nettype none

package ctc_pkg;

   localparam int ANGLE_BITS  = 16;
   localparam int PERIOD_BITS = ANGLE_BITS + 1;
   localparam int COEF_BITS   = 16;
   // room for four times a numerator
   localparam int WIDE_BITS   = PERIOD_BITS + 2;
   localparam int STEP_BITS   = $clog2(PERIOD_BITS + 1);
   localparam int SHIFT_BITS  = $clog2(PERIOD_BITS + 1);

   typedef logic [ANGLE_BITS-1:0]         angle_type;
   typedef logic [PERIOD_BITS-1:0]        period_type;
   typedef logic [WIDE_BITS-1:0]          wide_type;
   typedef logic [STEP_BITS-1:0]          step_type;
   typedef logic [SHIFT_BITS-1:0]         shift_type;
   typedef logic signed [COEF_BITS-1:0]   coef_type;

   localparam coef_type   COEF_MIN    = {1'b1, {(COEF_BITS-1){1'b0}}};
   localparam coef_type   COEF_MAX    = {1'b0, {(COEF_BITS-1){1'b1}}};
   localparam period_type SIXTH_DEN   = period_type'(6);
   localparam period_type QUARTER_DEN = period_type'(4);
   localparam period_type UNIT_NUM    = period_type'(1);

   typedef struct packed {
      logic signed [COEF_BITS-1:0]  coef_in;
      logic signed [ANGLE_BITS-1:0] angle_num;
      logic signed [ANGLE_BITS-1:0] period;
   } req_type;

   typedef struct packed {
      logic signed [COEF_BITS-1:0] coef_out;
      logic [ANGLE_BITS-1:0]       angle_num_out;
      logic [PERIOD_BITS-1:0]      period_out;
      logic                        period_zero;
   } rsp_type;

   typedef enum logic [1:0] {
      DIV_SEL_MOD,
      DIV_SEL_NUM,
      DIV_SEL_DEN
   } div_sel_type;

   typedef struct packed {
      logic        load;
      logic        div_start;
      div_sel_type div_sel;
      logic        take_mod;
      logic        half_fold;
      logic        quarter_fold;
      logic        gcd_init;
      logic        gcd_step;
      logic        take_num;
      logic        take_den;
      logic        finish;
   } cmd_type;

   typedef struct packed {
      logic period_zero;
      logic div_busy;
      logic gcd_done;
      logic out_free;
   } status_type;

   // Negation that maps the most negative code to the most positive one.
   function automatic coef_type neg_sat(input coef_type c);
      coef_type r;
      if (c == COEF_MIN) begin
         r = COEF_MAX;
      end else begin
         r = -c;
      end
      return r;
   endfunction

   // Unsigned magnitude of a two's complement angle field.
   function automatic angle_type magnitude(input angle_type v);
      angle_type r;
      if (v[ANGLE_BITS-1]) begin
         r = ~v + angle_type'(1);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### src/ctc_divider.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
`default_nettype none

module ctc_divider (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire ctc_pkg::period_type dividend,
   input  wire ctc_pkg::period_type divisor,
   output logic                    busy,
   output ctc_pkg::period_type     quotient,
   output ctc_pkg::period_type     remainder
);
   import ctc_pkg::*;

   step_type   step_ff, step_in;
   period_type quo_ff, quo_in;
   period_type rem_ff, rem_in;
   period_type dvs_ff, dvs_in;

   logic [PERIOD_BITS:0] trial;
   logic [PERIOD_BITS:0] diff;
   logic                 fits;

   // One partial remainder step
   always_comb begin
      trial = {rem_ff, quo_ff[PERIOD_BITS-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = trial >= {1'b0, dvs_ff};
   end

   always_comb begin
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         step_in = step_type'(PERIOD_BITS);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (step_ff != '0) begin
         step_in = step_ff - step_type'(1);
         quo_in  = {quo_ff[PERIOD_BITS-2:0], fits};
         rem_in  = fits ? diff[PERIOD_BITS-1:0] : trial[PERIOD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = (step_ff != '0);
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

### src/ctc_datapath.sv
// Datapath: operand registers, folds, binary GCD, shared divider and result register.
`default_nettype none
`include "cosine_term_canonicalizer_assert.svh"

module ctc_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ctc_pkg::cmd_type    cmd,
   output ctc_pkg::status_type      status,
   input  wire ctc_pkg::req_type    req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output ctc_pkg::rsp_type         rsp_data
);
   import ctc_pkg::*;

   coef_type   coef_ff, coef_in;
   period_type num_ff, num_in;
   period_type den_ff, den_in;
   logic       zero_ff, zero_in;
   period_type gcd_a_ff, gcd_a_in;
   period_type gcd_b_ff, gcd_b_in;
   shift_type  shift_ff, shift_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_data_ff, out_data_in;

   angle_type  num_mag;
   angle_type  den_mag;
   wide_type   num_wide;
   wide_type   den_wide;
   logic       half_hit;
   logic       quarter_hit;
   period_type gcd_val;
   logic       gcd_done;
   logic       rule_sixth;
   logic       rule_quarter;

   period_type div_dividend;
   period_type div_divisor;
   logic       div_busy;
   period_type div_quo;
   period_type div_rem;

   // Shared divider: modulo first, then the two divisions by the GCD
   always_comb begin
      case (cmd.div_sel)
         DIV_SEL_MOD: begin
            div_dividend = num_ff;
            div_divisor  = den_ff;
         end
         DIV_SEL_NUM: begin
            div_dividend = num_ff;
            div_divisor  = gcd_val;
         end
         DIV_SEL_DEN: begin
            div_dividend = den_ff;
            div_divisor  = gcd_val;
         end
         default: begin
            div_dividend = num_ff;
            div_divisor  = den_ff;
         end
      endcase
   end

   ctc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Decisions on the current fraction
   always_comb begin
      num_mag      = magnitude(req_data.angle_num);
      den_mag      = magnitude(req_data.period);
      num_wide     = wide_type'(num_ff);
      den_wide     = wide_type'(den_ff);
      half_hit     = (num_wide << 1) > den_wide;
      quarter_hit  = (num_wide << 2) > den_wide;
      gcd_done     = (gcd_a_ff == '0) || (gcd_b_ff == '0);
      gcd_val      = (gcd_a_ff | gcd_b_ff) << shift_ff;
      rule_sixth   = !coef_ff[0] && (num_ff == UNIT_NUM) && (den_ff == SIXTH_DEN);
      rule_quarter = (num_ff == UNIT_NUM) && (den_ff == QUARTER_DEN);
   end

   // Working registers
   always_comb begin
      coef_in  = coef_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      zero_in  = zero_ff;
      gcd_a_in = gcd_a_ff;
      gcd_b_in = gcd_b_ff;
      shift_in = shift_ff;
      if (cmd.load) begin
         coef_in = req_data.coef_in;
         if (den_mag == '0) begin
            num_in  = '0;
            den_in  = UNIT_NUM;
            zero_in = 1'b1;
         end else begin
            num_in  = period_type'(num_mag);
            den_in  = period_type'(den_mag);
            zero_in = 1'b0;
         end
      end else if (cmd.take_mod) begin
         num_in = div_rem;
      end else if (cmd.half_fold) begin
         if (half_hit) begin
            coef_in = neg_sat(coef_ff);
            if (den_ff[0]) begin
               num_in = (num_ff << 1) - den_ff;
               den_in = den_ff << 1;
            end else begin
               num_in = num_ff - (den_ff >> 1);
            end
         end
      end else if (cmd.quarter_fold) begin
         if (quarter_hit) begin
            coef_in = neg_sat(coef_ff);
            if (den_ff[0]) begin
               num_in = den_ff - (num_ff << 1);
               den_in = den_ff << 1;
            end else begin
               num_in = (den_ff >> 1) - num_ff;
            end
         end
      end else if (cmd.gcd_init) begin
         gcd_a_in = num_ff;
         gcd_b_in = den_ff;
         shift_in = '0;
      end else if (cmd.gcd_step) begin
         // binary GCD: strip common twos, halve a lone even operand, then odd-odd subtraction
         if (!gcd_a_ff[0] && !gcd_b_ff[0]) begin
            gcd_a_in = gcd_a_ff >> 1;
            gcd_b_in = gcd_b_ff >> 1;
            shift_in = shift_ff + shift_type'(1);
         end else if (!gcd_a_ff[0]) begin
            gcd_a_in = gcd_a_ff >> 1;
         end else if (!gcd_b_ff[0]) begin
            gcd_b_in = gcd_b_ff >> 1;
         end else if (gcd_a_ff >= gcd_b_ff) begin
            gcd_a_in = gcd_a_ff - gcd_b_ff;
         end else begin
            gcd_b_in = gcd_b_ff - gcd_a_ff;
         end
      end else if (cmd.take_num) begin
         num_in = div_quo;
      end else if (cmd.take_den) begin
         den_in = div_quo;
      end
   end

   // Result register with exact-value rules
   always_comb begin
      out_data_in = out_data_ff;
      if (cmd.finish) begin
         out_data_in.coef_out      = coef_ff;
         out_data_in.angle_num_out = num_ff[ANGLE_BITS-1:0];
         out_data_in.period_out    = den_ff;
         out_data_in.period_zero   = zero_ff;
         if (rule_sixth) begin
            out_data_in.coef_out      = coef_ff >>> 1;
            out_data_in.angle_num_out = '0;
            out_data_in.period_out    = UNIT_NUM;
         end else if (rule_quarter) begin
            out_data_in.coef_out      = '0;
            out_data_in.angle_num_out = '0;
            out_data_in.period_out    = UNIT_NUM;
         end
      end
      if (cmd.finish) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      coef_ff     <= coef_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      zero_ff     <= zero_in;
      gcd_a_ff    <= gcd_a_in;
      gcd_b_ff    <= gcd_b_in;
      shift_ff    <= shift_in;
      out_data_ff <= out_data_in;
   end

   // Status to the controller
   always_comb begin
      status.period_zero = zero_ff;
      status.div_busy    = div_busy;
      status.gcd_done    = gcd_done;
      status.out_free    = !out_valid_ff || !rsp_stall;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `CTC_ASSERT_IMPLY(a_mod_below_den, clock, reset, cmd.take_mod, div_rem < den_ff, "modulo not below period")
   `CTC_ASSERT_NEXT(a_quarter_bound, clock, reset, cmd.quarter_fold, (wide_type'(num_ff) << 2) <= wide_type'(den_ff), "angle above a quarter after folds")
   `CTC_ASSERT_IMPLY(a_den_divisible, clock, reset, cmd.take_den, div_rem == '0, "period not divisible by its GCD")

endmodule

`default_nettype wire

### src/ctc_controller.sv
// Controller state machine sequencing one transaction through the datapath.
`default_nettype none
`include "cosine_term_canonicalizer_assert.svh"

module ctc_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output ctc_pkg::cmd_type          cmd,
   input  wire ctc_pkg::status_type  status
);
   import ctc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MOD,
      ST_HALF,
      ST_QUARTER,
      ST_GCD_INIT,
      ST_GCD,
      ST_DIV_NUM,
      ST_DIV_DEN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.div_sel = DIV_SEL_MOD;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.period_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_SEL_MOD;
               state_in      = ST_MOD;
            end
         end
         ST_MOD: begin
            if (!status.div_busy) begin
               cmd.take_mod = 1'b1;
               state_in     = ST_HALF;
            end
         end
         ST_HALF: begin
            cmd.half_fold = 1'b1;
            state_in      = ST_QUARTER;
         end
         ST_QUARTER: begin
            cmd.quarter_fold = 1'b1;
            state_in         = ST_GCD_INIT;
         end
         ST_GCD_INIT: begin
            cmd.gcd_init = 1'b1;
            state_in     = ST_GCD;
         end
         ST_GCD: begin
            if (status.gcd_done) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_SEL_NUM;
               state_in      = ST_DIV_NUM;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIV_NUM: begin
            if (!status.div_busy) begin
               cmd.take_num  = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_SEL_DEN;
               state_in      = ST_DIV_DEN;
            end
         end
         ST_DIV_DEN: begin
            cmd.div_sel = DIV_SEL_DEN;
            if (!status.div_busy) begin
               cmd.take_den = 1'b1;
               state_in     = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   `CTC_ASSERT_IMPLY(a_div_start_idle, clock, reset, cmd.div_start, !status.div_busy, "divider started while busy")
   `CTC_ASSERT_IMPLY(a_finish_room, clock, reset, cmd.finish, status.out_free, "result written over a pending transaction")
   `CTC_ASSERT_IMPLY(a_gcd_step_live, clock, reset, cmd.gcd_step, !status.gcd_done, "GCD stepped after completion")

endmodule

`default_nettype wire

### src/cosine_term_canonicalizer.sv
// Top level of the cosine term canonicalizer: controller plus datapath.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_data  (coef_in, angle_num, period)
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_data  (coef_out, angle_num_out,
//           |           |                      |            period_out, period_zero)
//
// One transaction at a time; the shared 17-step divider runs three times
// (modulo, numerator and period over the GCD), with the binary GCD steps
// between the first run and the other two.
// A zero period skips the divider and the GCD and goes straight to the result.
// Synchronous active-high reset clears the controller and the result valid.
// A stalled result holds in its output register while the next request is taken.
`default_nettype none

module cosine_term_canonicalizer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ctc_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ctc_pkg::rsp_type       rsp_data
);
   import ctc_pkg::*;

   cmd_type    cmd;
   status_type status;

   ctc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   ctc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
